[hw/rtl/swrl_pkg.sv]
// ----------------------------------------------------------------------------
// swrl_pkg: shared definitions for the sliding window rate limiter
// Field widths, register indexes, operation codes and reset values.
// ----------------------------------------------------------------------------
package swrl_pkg;

  // Default storage geometry
  localparam int unsigned DEF_LOG_DEPTH  = 1024;
  localparam int unsigned DEF_STAMP_BITS = 32;

  // Fixed field widths
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned MAX_GRANTS_W = 11;
  localparam int unsigned WINDOW_W     = 31;
  localparam int unsigned AVAIL_W      = 11;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 31;

  // Operation codes; the unused code behaves as observe
  localparam logic [FUNC_W-1:0] FUNC_OBSERVE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GRANTS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'b1;

  // Register reset values
  localparam logic [MAX_GRANTS_W-1:0] MAX_GRANTS_RST   = 11'd1024;
  localparam logic [WINDOW_W-1:0]     WINDOW_TICKS_RST = 31'd60;

endpackage

[hw/rtl/sliding_window_rate_limiter.sv]
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter: sliding-window-log rate limiter
// Keeps a ring log of grant stamps, expires old entries oldest first, and
// admits an acquire only while fewer than the limit remain in the window.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   input    | in_valid_i / in_stall_o    | func_i, now_i
//   output   | out_valid_o / out_stall_i  | granted_o, available_o
//   config   | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// An item is handled in steps: accept it and read the oldest stamp, pop
// each expired entry (each pop reads the next stamp through the log's single
// registered read port), and last decide and load the result register.
// The log needs no clearing pass after reset: the fill count guards every read.
// A stalled result holds in the output register; the block finishes the next
// item's expiry meanwhile and waits only to load its result.
module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH  = DEF_LOG_DEPTH,
  parameter int unsigned STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [STAMP_BITS-1:0] now_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output logic [AVAIL_W-1:0]    available_o
);

  // Ring index, fill count and compare widths
  localparam int unsigned IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned LIM_W = (CNT_W > MAX_GRANTS_W) ? CNT_W : MAX_GRANTS_W;
  localparam int unsigned AGE_W = (STAMP_BITS > WINDOW_W) ? STAMP_BITS : WINDOW_W;

  // Sequencer codes
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_CHECK = 1'b1;

  // Configuration registers
  logic [MAX_GRANTS_W-1:0] max_grants_q;
  logic [WINDOW_W-1:0]     window_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_grants_q   <= MAX_GRANTS_RST;
      window_ticks_q <= WINDOW_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_GRANTS:   max_grants_q   <= cfg_data_i[MAX_GRANTS_W-1:0];
        REG_WINDOW_TICKS: window_ticks_q <= cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and item state
  logic                  state_q, state_d;
  logic [IDX_W-1:0]      oldest_q, oldest_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [FUNC_W-1:0]     func_q;
  logic [STAMP_BITS-1:0] now_q;
  logic                  out_valid_q, out_valid_d;
  logic                  granted_q, granted_d;
  logic [AVAIL_W-1:0]    avail_q, avail_d;

  // Log port
  logic                  log_we;
  logic [IDX_W-1:0]      log_waddr;
  logic                  log_re;
  logic [STAMP_BITS-1:0] log_rdata;

  // Datapath helpers
  logic                  in_fire;
  logic                  out_free;
  logic [STAMP_BITS-1:0] age;
  logic                  expired;
  logic [MAX_GRANTS_W-1:0] limit;
  logic [LIM_W-1:0]      limit_ext;
  logic [LIM_W-1:0]      count_ext;
  logic [LIM_W-1:0]      count_new_ext;
  logic [CNT_W-1:0]      count_new;
  logic                  grant;
  logic [SUM_W-1:0]      wr_sum;
  logic [IDX_W-1:0]      oldest_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Effective limit: never above the log depth
  always_comb begin
    if (32'(max_grants_q) > 32'(LOG_DEPTH)) begin
      limit = MAX_GRANTS_W'(LOG_DEPTH);
    end else begin
      limit = max_grants_q;
    end
  end
  assign limit_ext = LIM_W'(limit);
  assign count_ext = LIM_W'(count_q);

  // Age of the oldest entry, modular in the stamp width
  assign age     = now_q - log_rdata;
  assign expired = (count_q != '0) && (AGE_W'(age) > AGE_W'(window_ticks_q));

  // Ring arithmetic: next oldest slot, and the slot behind the newest entry
  assign oldest_inc = (oldest_q == IDX_W'(LOG_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
  always_comb begin
    wr_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
    if (wr_sum >= SUM_W'(LOG_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(LOG_DEPTH);
    end
  end
  assign log_waddr = wr_sum[IDX_W-1:0];

  assign grant = (func_q == FUNC_ACQUIRE) && (count_ext < limit_ext);

  always_comb begin
    case (func_q)
      FUNC_CLEAR: count_new = '0;
      FUNC_ACQUIRE: begin
        count_new = grant ? count_q + 1'b1 : count_q;
      end
      default: count_new = count_q;
    endcase
  end
  assign count_new_ext = LIM_W'(count_new);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    granted_d   = granted_q;
    avail_d     = avail_q;
    log_we      = 1'b0;
    log_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        // Read the oldest stamp while the item is taken in
        if (in_fire) begin
          log_re  = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (expired) begin
          // Drop the oldest entry and fetch the next one
          oldest_d = oldest_inc;
          count_d  = count_q - 1'b1;
          log_re   = 1'b1;
        end else if (out_free) begin
          // Act on the item and load the result
          log_we      = grant;
          count_d     = count_new;
          out_valid_d = 1'b1;
          granted_d   = grant;
          avail_d     = (count_new_ext >= limit_ext) ? '0
                                                     : AVAIL_W'(limit_ext - count_new_ext);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      now_q  <= now_i;
    end
    granted_q <= granted_d;
    avail_q   <= avail_d;
  end

  swrl_log #(
    .DEPTH  (LOG_DEPTH),
    .DATA_W (STAMP_BITS)
  ) u_log (
    .clk_i     (clk_i),
    .wr_en_i   (log_we),
    .wr_addr_i (log_waddr),
    .wr_data_i (now_q),
    .rd_en_i   (log_re),
    .rd_addr_i (oldest_d),
    .rd_data_o (log_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign available_o = avail_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LIM_W'(count_q) <= LIM_W'(limit) || LIM_W'(count_q) <= $past(LIM_W'(count_q)))
    else $error("entry count grew beyond the limit");

  a_oldest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(oldest_q) < 32'(LOG_DEPTH))
    else $error("oldest index out of ring range");

  a_result_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_CHECK)
    else $error("result loaded outside the decision step");

  a_grant_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_we |=> count_q == $past(count_q) + 1'b1)
    else $error("logged grant did not advance the entry count");

endmodule

[hw/rtl/swrl_log.sv]
// ----------------------------------------------------------------------------
// swrl_log: grant stamp memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module swrl_log #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 32,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[dv/sliding_window_rate_limiter_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_test: self-checking bench for the rate limiter
// Drives a short table of hand-checked items and register writes, then
// random phases under several limit and window settings, and compares every
// result with its hand-checked value or an in-bench model of the grant log.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_rate_limiter_test;
  import swrl_pkg::*;

  localparam int unsigned LOG_DEPTH       = DEF_LOG_DEPTH;
  localparam int unsigned STAMP_W         = DEF_STAMP_BITS;
  // The fourth func code has no name in the package; it acts as observe.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int PHASE_COUNT     = 10;
  localparam int PHASE_ITEMS     = 63;
  localparam int HOLD_AFTER      = 300;    // results seen before the long hold
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = LOG_DEPTH + 80;
  localparam int WATCHDOG_LIMIT  = 20000;

  typedef struct packed {
    logic               granted;
    logic [AVAIL_W-1:0] available;
  } verdict_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [FUNC_W-1:0]     func;
    logic [STAMP_W-1:0]    stamp;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    bit                    typed;
    verdict_t              verdict;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [FUNC_W-1:0]     func_i;
  logic [STAMP_W-1:0]    now_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  granted_o;
  logic [AVAIL_W-1:0]    available_o;

  // Model of the grant log: ring of stamps, oldest slot, live count, registers.
  logic [STAMP_W-1:0]      grant_stamps [LOG_DEPTH];
  int unsigned             oldest_slot;
  int unsigned             live_grants;
  logic [MAX_GRANTS_W-1:0] limit_reg;
  logic [WINDOW_W-1:0]     window_reg;

  verdict_t  expected_verdicts [$];
  plan_row_t directed_plan [$];
  verdict_t  seen_verdict;

  int errors;
  int results_seen;
  int idle_cycles;
  int burst_left;
  int items_sent;
  int grants_made;
  int refusals;
  int clears_seen;
  int writes_done;

  sliding_window_rate_limiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .now_i       (now_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .granted_o   (granted_o),
    .available_o (available_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Expire, then admit, clear or just report. Ages wrap at the stamp width, so
  // a stamp that lies ahead of now looks very old and is dropped.
  function automatic verdict_t decide_admission(input logic [FUNC_W-1:0] func,
                                                input logic [STAMP_W-1:0] stamp);
    verdict_t    v;
    int unsigned ceiling;
    ceiling = (limit_reg > LOG_DEPTH) ? LOG_DEPTH : limit_reg;
    while (live_grants > 0 &&
           STAMP_W'(stamp - grant_stamps[oldest_slot]) > STAMP_W'(window_reg)) begin
      oldest_slot = (oldest_slot + 1) % LOG_DEPTH;
      live_grants--;
    end
    v.granted = 1'b0;
    case (func)
      FUNC_ACQUIRE: begin
        if (live_grants < ceiling) begin
          grant_stamps[(oldest_slot + live_grants) % LOG_DEPTH] = stamp;
          live_grants++;
          v.granted = 1'b1;
          grants_made++;
        end else begin
          refusals++;
        end
      end
      FUNC_CLEAR: begin
        live_grants = 0;
        clears_seen++;
      end
      default: ;
    endcase
    v.available = (live_grants >= ceiling) ? '0 : AVAIL_W'(ceiling - live_grants);
    return v;
  endfunction

  // Mostly short gaps, some long ones, and bursts with none at all.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic plan_item(input logic [FUNC_W-1:0] func, input logic [STAMP_W-1:0] stamp,
                           input bit typed, input logic granted,
                           input logic [AVAIL_W-1:0] available);
    plan_row_t row;
    row.kind              = ROW_ITEM;
    row.func              = func;
    row.stamp             = stamp;
    row.reg_idx           = '0;
    row.reg_data          = '0;
    row.typed             = typed;
    row.verdict.granted   = granted;
    row.verdict.available = available;
    directed_plan = {directed_plan, row};
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row.kind     = ROW_WRITE;
    row.func     = FUNC_OBSERVE;
    row.stamp    = '0;
    row.reg_idx  = idx;
    row.reg_data = data;
    row.typed    = 1'b0;
    row.verdict  = '0;
    directed_plan = {directed_plan, row};
  endtask

  // Offer one item after a random gap and hold it until accepted. Returns on
  // the accepting edge so the next item can follow back to back.
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [STAMP_W-1:0] stamp,
                           input bit typed, input verdict_t typed_verdict);
    int       gap;
    verdict_t model_verdict;
    verdict_t queued_verdict;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    now_i      <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    model_verdict  = decide_admission(func, stamp);
    queued_verdict = typed ? typed_verdict : model_verdict;
    expected_verdicts = {expected_verdicts, queued_verdict};
    items_sent++;
  endtask

  // Stop offering, let every outstanding result drain, then write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_MAX_GRANTS) limit_reg = data[MAX_GRANTS_W-1:0];
    else window_reg = data[WINDOW_W-1:0];
    writes_done++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stalls with quiet stretches, plus one long hold-off
  // while the sender keeps offering, so the block backs up into its input.
  initial begin
    int  quiet_left;
    int  r;
    bit  held_off;
    quiet_left = 0;
    held_off   = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= HOLD_AFTER && in_valid_i) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (quiet_left > 0) begin
        quiet_left--;
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          quiet_left = $urandom_range(20, 80);
          out_stall_i <= 1'b0;
        end else if (r < 40) begin
          out_stall_i <= 1'b1;
          repeat (pick_stall() - 1) @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Check each accepted result against the oldest expectation, and count
  // cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with none expected: granted %0b available %0d",
                   $time, granted_o, available_o);
          errors++;
        end else begin
          seen_verdict = expected_verdicts.pop_front();
          if (granted_o !== seen_verdict.granted) begin
            $display("%0t: granted mismatch: expected %0b actual %0b",
                     $time, seen_verdict.granted, granted_o);
            errors++;
          end
          if (available_o !== seen_verdict.available) begin
            $display("%0t: available mismatch: expected %0d actual %0d",
                     $time, seen_verdict.available, available_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int                    r;
    int unsigned           span;
    logic [STAMP_W-1:0]    clock_now;
    logic [STAMP_W-1:0]    hop;
    logic [MAX_GRANTS_W-1:0] max_pick;
    logic [WINDOW_W-1:0]   win_pick;
    logic [FUNC_W-1:0]     func_pick;

    errors       = 0;
    results_seen = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    items_sent   = 0;
    grants_made  = 0;
    refusals     = 0;
    clears_seen  = 0;
    writes_done  = 0;
    oldest_slot  = 0;
    live_grants  = 0;
    limit_reg    = MAX_GRANTS_RST;
    window_reg   = WINDOW_TICKS_RST;

    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    func_i     <= FUNC_OBSERVE;
    now_i      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Reset settings first: limit 1024, window 60.
    plan_item(FUNC_OBSERVE, 32'h0000_0000, 1'b1, 1'b0, 11'd1024);
    plan_item(FUNC_ACQUIRE, 32'h0000_0000, 1'b1, 1'b1, 11'd1023);
    plan_item(FUNC_UNUSED,  32'h0000_0000, 1'b1, 1'b0, 11'd1023);
    plan_item(FUNC_CLEAR,   32'h0000_0005, 1'b1, 1'b0, 11'd1024);
    plan_item(FUNC_ACQUIRE, 32'h0000_000A, 1'b1, 1'b1, 11'd1023);
    // age exactly equal to the window keeps the entry
    plan_item(FUNC_ACQUIRE, 32'h0000_0046, 1'b1, 1'b1, 11'd1022);
    // one tick later the first grant falls out
    plan_item(FUNC_OBSERVE, 32'h0000_0047, 1'b0, 1'b0, '0);
    plan_item(FUNC_ACQUIRE, 32'hFFFF_FFFF, 1'b1, 1'b1, 11'd1023);
    // stamp wraps to zero: the last grant is only one tick old
    plan_item(FUNC_OBSERVE, 32'h0000_0000, 1'b0, 1'b0, '0);
    // time steps back: the stamp ahead of now looks ancient and expires
    plan_item(FUNC_OBSERVE, 32'hFFFF_FFF0, 1'b1, 1'b0, 11'd1024);
    // a limit of zero grants nothing
    plan_write(REG_MAX_GRANTS, 31'd0);
    plan_item(FUNC_ACQUIRE, 32'h0000_0064, 1'b1, 1'b0, 11'd0);
    plan_item(FUNC_OBSERVE, 32'h0000_0064, 1'b0, 1'b0, '0);
    // a limit above the log depth is clipped to the depth
    plan_write(REG_MAX_GRANTS, 31'd2047);
    plan_item(FUNC_OBSERVE, 32'h0000_0064, 1'b1, 1'b0, 11'd1024);
    plan_item(FUNC_ACQUIRE, 32'h0000_0064, 1'b1, 1'b1, 11'd1023);
    // zero window: anything older than now expires
    plan_write(REG_MAX_GRANTS, 31'd1);
    plan_write(REG_WINDOW_TICKS, 31'd0);
    plan_item(FUNC_ACQUIRE, 32'h0000_00C8, 1'b1, 1'b1, 11'd0);
    plan_item(FUNC_ACQUIRE, 32'h0000_00C8, 1'b1, 1'b0, 11'd0);
    plan_item(FUNC_OBSERVE, 32'h0000_00C9, 1'b1, 1'b0, 11'd1);
    // widest window, across the half-range boundary
    plan_write(REG_WINDOW_TICKS, 31'h7FFF_FFFF);
    plan_write(REG_MAX_GRANTS, 31'd2);
    plan_item(FUNC_ACQUIRE, 32'h0000_0000, 1'b1, 1'b1, 11'd1);
    plan_item(FUNC_ACQUIRE, 32'h7FFF_FFFF, 1'b1, 1'b1, 11'd0);
    plan_item(FUNC_ACQUIRE, 32'h8000_0000, 1'b1, 1'b1, 11'd0);
    plan_item(FUNC_CLEAR,   32'h8000_0001, 1'b1, 1'b0, 11'd2);
    plan_item(FUNC_ACQUIRE, 32'h8000_0001, 1'b1, 1'b1, 11'd1);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE)
        write_register(directed_plan[i].reg_idx, directed_plan[i].reg_data);
      else
        send_item(directed_plan[i].func, directed_plan[i].stamp,
                  directed_plan[i].typed, directed_plan[i].verdict);
    end

    // Random phases, each under its own limit and window.
    clock_now = '0;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin max_pick = 11'd3;    win_pick = 31'd10;          end
        1: begin max_pick = 11'd2047; win_pick = 31'h7FFF_FFFF;   end
        2: begin max_pick = 11'd1;    win_pick = 31'd0;           end
        3: begin max_pick = 11'd1024; win_pick = 31'd1;           end
        4: begin
          max_pick = MAX_GRANTS_W'($urandom_range(1, 16));
          win_pick = WINDOW_W'($urandom_range(2, 200));
        end
        5: begin max_pick = 11'd0; win_pick = WINDOW_W'($urandom_range(0, 100)); end
        6: begin
          max_pick = MAX_GRANTS_W'($urandom_range(0, 2047));
          win_pick = WINDOW_W'($urandom());
        end
        7: begin
          max_pick = MAX_GRANTS_W'($urandom_range(1, 8));
          win_pick = WINDOW_W'($urandom_range(1, 50));
        end
        8: begin
          max_pick = MAX_GRANTS_W'($urandom_range(2, 64));
          win_pick = WINDOW_W'($urandom_range(0, 30));
        end
        default: begin
          max_pick = MAX_GRANTS_W'($urandom_range(1, 2047));
          win_pick = WINDOW_W'($urandom_range(0, 1000));
        end
      endcase
      // upper data bits beyond the limit field carry noise
      write_register(REG_MAX_GRANTS,
                     {(CFG_DATA_W - MAX_GRANTS_W)'($urandom()), max_pick});
      write_register(REG_WINDOW_TICKS, win_pick);
      if (phase % 3 == 0) clock_now = $urandom();
      span = (win_pick < 1000) ? win_pick + win_pick / 2 + 2 : 1000;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Advance time mostly in small steps, sometimes past the window,
        // rarely by an arbitrary jump or backwards.
        r = $urandom_range(0, 99);
        if (r < 55)      hop = $urandom_range(0, 2);
        else if (r < 85) hop = $urandom_range(0, span);
        else if (r < 94) hop = $urandom_range(0, STAMP_W'(win_pick) + 1);
        else if (r < 98) hop = $urandom();
        else             hop = STAMP_W'(0) - STAMP_W'($urandom_range(1, 50));
        clock_now = clock_now + hop;

        r = $urandom_range(0, 99);
        if (r < 58)      func_pick = FUNC_ACQUIRE;
        else if (r < 88) func_pick = FUNC_OBSERVE;
        else if (r < 94) func_pick = FUNC_CLEAR;
        else             func_pick = FUNC_UNUSED;
        send_item(func_pick, clock_now, 1'b0, '0);
      end
    end

    // Drain, then watch a while longer for stray results.
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d items over %0d register writes; %0d grants, %0d refusals, %0d clears",
             items_sent, writes_done, grants_made, refusals, clears_seen);
    $display("summary: %0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
